@@ design/self_avoiding_grid_walk_core_macros.svh @@
// Assertion macros for the checker file, sagw_checker.sv.
`ifndef SELF_AVOIDING_GRID_WALK_CORE_MACROS_SVH
`define SELF_AVOIDING_GRID_WALK_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SAGW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sagw: implication failed");

// Next-cycle implication, disabled while reset is asserted
`define SAGW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sagw: next-cycle implication failed");

`endif

@@ design/sagw_pkg.sv @@
package sagw_pkg;

    localparam int LABEL_W  = 5;
    localparam int STATUS_W = 3;

    // Operation codes
    localparam logic [1:0] OP_MOVE    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Direction codes
    localparam logic [1:0] DIR_ROW_INC = 2'd0;
    localparam logic [1:0] DIR_COL_INC = 2'd1;
    localparam logic [1:0] DIR_ROW_DEC = 2'd2;
    localparam logic [1:0] DIR_COL_DEC = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MOVED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STUCK    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RESTART  = 3'd5;

    // Cell labels
    localparam logic [LABEL_W-1:0] LABEL_EMPTY = 5'd0;
    localparam logic [LABEL_W-1:0] LABEL_A     = 5'd1;
    localparam logic [LABEL_W-1:0] LABEL_B     = 5'd2;
    localparam logic [LABEL_W-1:0] LABEL_Z     = 5'd26;

    localparam logic [3:0] ALL_TRIED = 4'hf;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] direction;
        logic [3:0] read_row;
        logic [3:0] read_col;
    } sagw_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [3:0]          walker_row;
        logic [3:0]          walker_col;
        logic [LABEL_W-1:0]  cell_label;
    } sagw_out_t;

endpackage

@@ design/self_avoiding_grid_walk_core.sv @@
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_valid / s_ready  | s_data : op, direction, read_row, read_col
// m_      | out | m_valid / m_ready  | m_data : status, walker_row, walker_col, cell_label
//
// Every transaction: the accept cycle issues the grid read, then the evaluate
// state evaluates it, writes a moved walker's new label back and loads m_data.
// Reset and every restart run a clearing pass over all GRID_SIDE*GRID_SIDE cells
// of the grid memory, one cell a cycle, with s_ready low.
// A result waiting on m_ready does not block the next accept; the evaluate
// cycle of that next transaction waits until the output register is free.
module self_avoiding_grid_walk_core #(
    parameter int GRID_SIDE = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sagw_pkg::sagw_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sagw_pkg::sagw_out_t m_data
);
    import sagw_pkg::*;

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CW-1:0] MAX_COORD = CW'(GRID_SIDE - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]      pos_row_reg, pos_row_next;
    logic [CW-1:0]      pos_col_reg, pos_col_next;
    logic [3:0]         tried_reg, tried_next;
    logic [LABEL_W-1:0] label_reg, label_next;
    logic               over_reg, over_next;
    logic               m_valid_reg, m_valid_next;
    sagw_out_t          m_data_reg, m_data_next;

    // Captured transaction
    logic [1:0]    op_reg;
    logic [1:0]    dir_reg;
    logic          bound_ok_reg;
    logic          rd_ok_reg;
    logic [CW-1:0] tgt_row_reg, tgt_col_reg;
    logic [AW-1:0] tgt_addr_reg;

    logic               accept;
    logic               out_free;
    logic               bound_ok;
    logic [CW-1:0]      tgt_row, tgt_col;
    logic [AW-1:0]      tgt_addr, rd_addr;
    logic               rd_ok;
    logic [3:0]         tried_upd;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [LABEL_W-1:0] ram_wdata;
    logic [LABEL_W-1:0] ram_rdata;
    logic [STATUS_W-1:0] res_status;
    logic [LABEL_W-1:0] res_label;
    logic               out_load;

    // Walker coordinate to the 4-bit result field (modulo 16)
    function automatic logic [3:0] to_field(input logic [CW-1:0] c);
        logic [CW+3:0] wide;
        wide = {4'b0000, c};
        return wide[3:0];
    endfunction

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Target cell of a move from the current position
    always_comb begin
        bound_ok = 1'b1;
        tgt_row  = pos_row_reg;
        tgt_col  = pos_col_reg;
        unique case (s_data.direction)
            DIR_ROW_INC: begin
                bound_ok = (pos_row_reg != MAX_COORD);
                tgt_row  = pos_row_reg + CW'(1);
            end
            DIR_COL_INC: begin
                bound_ok = (pos_col_reg != MAX_COORD);
                tgt_col  = pos_col_reg + CW'(1);
            end
            DIR_ROW_DEC: begin
                bound_ok = (pos_row_reg != '0);
                tgt_row  = pos_row_reg - CW'(1);
            end
            DIR_COL_DEC: begin
                bound_ok = (pos_col_reg != '0);
                tgt_col  = pos_col_reg - CW'(1);
            end
            default: ;
        endcase
    end

    assign tgt_addr = AW'(int'(tgt_row) * GRID_SIDE + int'(tgt_col));
    assign rd_ok    = (int'(s_data.read_row) < GRID_SIDE) &&
                      (int'(s_data.read_col) < GRID_SIDE);
    assign rd_addr  = AW'(int'(s_data.read_row) * GRID_SIDE + int'(s_data.read_col));
    assign tried_upd = tried_reg | (4'b0001 << dir_reg);

    sagw_ram #(
        .WIDTH(LABEL_W),
        .DEPTH(DEPTH)
    ) u_grid (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (accept),
        .raddr((s_data.op == OP_READ) ? rd_addr : tgt_addr),
        .rdata(ram_rdata)
    );

    // Sequencer: clear, accept, evaluate and write back
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pos_row_next = pos_row_reg;
        pos_col_next = pos_col_reg;
        tried_next   = tried_reg;
        label_next   = label_reg;
        over_next    = over_reg;
        ram_we       = 1'b0;
        ram_waddr    = clr_cnt_reg;
        ram_wdata    = LABEL_EMPTY;
        res_status   = ST_REFUSED;
        res_label    = LABEL_EMPTY;
        out_load     = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = (clr_cnt_reg == '0) ? LABEL_A : LABEL_EMPTY;
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        OP_MOVE: begin
                            if (over_reg) begin
                                res_status = (label_reg > LABEL_Z) ? ST_COMPLETE : ST_STUCK;
                            end else if (!bound_ok_reg || ram_rdata != LABEL_EMPTY) begin
                                // refused: note the direction
                                tried_next = tried_upd;
                                if (tried_upd == ALL_TRIED) begin
                                    over_next  = 1'b1;
                                    res_status = ST_STUCK;
                                end
                            end else begin
                                pos_row_next = tgt_row_reg;
                                pos_col_next = tgt_col_reg;
                                ram_we       = 1'b1;
                                ram_waddr    = tgt_addr_reg;
                                ram_wdata    = label_reg;
                                res_label    = label_reg;
                                tried_next   = '0;
                                label_next   = label_reg + LABEL_W'(1);
                                if (label_reg >= LABEL_Z) begin
                                    over_next  = 1'b1;
                                    res_status = ST_COMPLETE;
                                end else begin
                                    res_status = ST_MOVED;
                                end
                            end
                        end
                        OP_READ: begin
                            res_status = ST_READ;
                            res_label  = rd_ok_reg ? ram_rdata : LABEL_EMPTY;
                        end
                        OP_RESTART: begin
                            pos_row_next = '0;
                            pos_col_next = '0;
                            tried_next   = '0;
                            label_next   = LABEL_B;
                            over_next    = 1'b0;
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                            res_status   = ST_RESTART;
                            res_label    = LABEL_A;
                        end
                        default: ;
                    endcase
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // Output register
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_data_next.status     = res_status;
            m_data_next.walker_row = to_field(pos_row_next);
            m_data_next.walker_col = to_field(pos_col_next);
            m_data_next.cell_label = res_label;
            m_valid_next           = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and walk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            pos_row_reg <= '0;
            pos_col_reg <= '0;
            tried_reg   <= '0;
            label_reg   <= LABEL_B;
            over_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pos_row_reg <= pos_row_next;
            pos_col_reg <= pos_col_next;
            tried_reg   <= tried_next;
            label_reg   <= label_next;
            over_reg    <= over_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            op_reg       <= s_data.op;
            dir_reg      <= s_data.direction;
            bound_ok_reg <= bound_ok;
            rd_ok_reg    <= rd_ok;
            tgt_row_reg  <= tgt_row;
            tgt_col_reg  <= tgt_col;
            tgt_addr_reg <= tgt_addr;
        end
    end

endmodule

@@ design/sagw_ram.sv @@
module sagw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/sagw_checker.sv @@
`include "self_avoiding_grid_walk_core_macros.svh"

module sagw_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input sagw_pkg::sagw_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input sagw_pkg::sagw_out_t m_data
);
    import sagw_pkg::*;

    // An offered transaction holds until accepted
    `SAGW_ASSERT_NEXT(a_in_hold, aclk, aresetn,
        s_valid && !s_ready, s_valid && $stable(s_data))

    // A stalled result holds
    `SAGW_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_data))

    // One transaction in the sequencer at a time
    `SAGW_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A restart puts the walker on the origin with label A
    `SAGW_ASSERT_IMPL(a_restart_origin, aclk, aresetn,
        m_valid && m_data.status == ST_RESTART,
        m_data.walker_row == 4'd0 && m_data.walker_col == 4'd0 &&
        m_data.cell_label == LABEL_A)

    // Refused and stuck results carry no label
    `SAGW_ASSERT_IMPL(a_refused_empty, aclk, aresetn,
        m_valid && (m_data.status == ST_REFUSED || m_data.status == ST_STUCK),
        m_data.cell_label == LABEL_EMPTY)

endmodule

bind self_avoiding_grid_walk_core sagw_checker u_sagw_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import sagw_pkg::*;

    localparam int GRID_SIDE    = 16;
    localparam int WALK_ITEMS   = 1400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 500;
    localparam int PAUSE_AT     = 900;

    // op code with no function; the block must answer it as a refusal
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Predicts the walker and checks each result against the oldest prediction
    class walk_scoreboard;
        logic [LABEL_W-1:0] cells [GRID_SIDE][GRID_SIDE];
        int                 cur_row;
        int                 cur_col;
        logic [3:0]         tried;
        logic [LABEL_W-1:0] next_lbl;
        bit                 over;
        sagw_out_t          awaited_q [$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        seen [8];

        function new();
            errors  = 0;
            checked = 0;
            foreach (seen[i]) seen[i] = 0;
            restart_walk();
        endfunction

        function void restart_walk();
            foreach (cells[r, c]) cells[r][c] = LABEL_EMPTY;
            cells[0][0] = LABEL_A;
            cur_row  = 0;
            cur_col  = 0;
            tried    = '0;
            next_lbl = LABEL_B;
            over     = 1'b0;
        endfunction

        // Target cell of a step; returns 0 when it leaves the grid
        function bit neighbour(input logic [1:0] dir, output int r, output int c);
            r = cur_row;
            c = cur_col;
            case (dir)
                DIR_ROW_INC: r = r + 1;
                DIR_COL_INC: c = c + 1;
                DIR_ROW_DEC: r = r - 1;
                default:     c = c - 1;
            endcase
            return (r >= 0 && r < GRID_SIDE && c >= 0 && c < GRID_SIDE);
        endfunction

        function bit is_free(input logic [1:0] dir);
            int r, c;
            return neighbour(dir, r, c) && cells[r][c] == LABEL_EMPTY;
        endfunction

        function void note_input(input sagw_in_t it);
            sagw_out_t res;
            int        r, c;
            res.cell_label = LABEL_EMPTY;
            case (it.op)
                OP_MOVE: begin
                    if (over) begin
                        res.status = (next_lbl > LABEL_Z) ? ST_COMPLETE : ST_STUCK;
                    end else if (neighbour(it.direction, r, c) &&
                                 cells[r][c] == LABEL_EMPTY) begin
                        cur_row        = r;
                        cur_col        = c;
                        cells[r][c]    = next_lbl;
                        res.cell_label = next_lbl;
                        tried          = '0;
                        over           = (next_lbl >= LABEL_Z);
                        res.status     = over ? ST_COMPLETE : ST_MOVED;
                        next_lbl       = next_lbl + 1'b1;
                    end else begin
                        tried[it.direction] = 1'b1;
                        over       = (tried == ALL_TRIED);
                        res.status = over ? ST_STUCK : ST_REFUSED;
                    end
                end
                OP_READ: begin
                    res.status = ST_READ;
                    if (it.read_row < GRID_SIDE && it.read_col < GRID_SIDE)
                        res.cell_label = cells[it.read_row][it.read_col];
                end
                OP_RESTART: begin
                    restart_walk();
                    res.status     = ST_RESTART;
                    res.cell_label = LABEL_A;
                end
                default: res.status = ST_REFUSED;
            endcase
            res.walker_row = cur_row[3:0];
            res.walker_col = cur_col[3:0];
            awaited_q.push_back(res);
        endfunction

        function void report(input string field, input logic [7:0] want,
                             input logic [7:0] got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(input sagw_out_t got);
            sagw_out_t want;
            if (awaited_q.size() == 0) begin
                $display("%0t: result with none expected, actual %p", $time, got);
                errors++;
                return;
            end
            want = awaited_q.pop_front();
            checked++;
            seen[want.status]++;
            if (got.status !== want.status)
                report("status", 8'(want.status), 8'(got.status));
            if (got.walker_row !== want.walker_row)
                report("walker_row", 8'(want.walker_row), 8'(got.walker_row));
            if (got.walker_col !== want.walker_col)
                report("walker_col", 8'(want.walker_col), 8'(got.walker_col));
            if (got.cell_label !== want.cell_label)
                report("cell_label", 8'(want.cell_label), 8'(got.cell_label));
        endfunction
    endclass

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sagw_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sagw_out_t m_data;

    walk_scoreboard sb = new();

    bit          hold_req   = 1'b0;
    bit          hold_done  = 1'b0;
    int unsigned burst_left = 0;
    int unsigned walk_items = 0;
    int unsigned quiet_cycles = 0;
    logic [1:0]  prev_dir   = DIR_ROW_INC;

    self_avoiding_grid_walk_core #(.GRID_SIDE(GRID_SIDE)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Offer one transaction and hold it until accepted
    task automatic send_item(input sagw_in_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [1:0] dir,
                               input logic [3:0] rr, input logic [3:0] rc);
        sagw_in_t it;
        it.op        = op;
        it.direction = dir;
        it.read_row  = rr;
        it.read_col  = rc;
        send_item(it);
    endtask

    // Sender bursts; a zero gap merges two bursts into one longer stretch
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Lower valid and wait until every awaited result has been checked
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.awaited_q.size() != 0);
    endtask

    // Mostly steered walks with momentum, some reads, restarts and noise
    function automatic sagw_in_t next_walk_item();
        sagw_in_t    it;
        int unsigned pick;
        int unsigned steer;
        logic [1:0]  free_dirs [$];
        it.op        = OP_MOVE;
        it.direction = 2'($urandom_range(0, 3));
        it.read_row  = 4'($urandom_range(0, 15));
        it.read_col  = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            it.op = OP_UNUSED;
        end else if (pick < 14) begin
            it.op = OP_READ;
            if (pick < 8) begin
                it.read_row = sb.cur_row[3:0];
                it.read_col = sb.cur_col[3:0];
            end
        end else if (sb.over ? (pick < 60) : (pick < 16)) begin
            it.op = OP_RESTART;
        end else begin
            steer = $urandom_range(0, 99);
            if (steer >= 10 && steer < 60) begin
                it.direction = prev_dir;
            end else if (steer >= 60) begin
                for (int d = 0; d < 4; d++)
                    if (sb.is_free(2'(d))) free_dirs.push_back(2'(d));
                if (free_dirs.size() != 0)
                    it.direction = free_dirs[$urandom_range(0, free_dirs.size() - 1)];
            end
            prev_dir = it.direction;
        end
        return it;
    endfunction

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: stretches of full, half and sparse readiness, plus one long hold
    initial begin : receiver
        int unsigned mode;
        int unsigned stretch;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (LONG_HOLD) begin
                    @(posedge aclk);
                    m_ready <= 1'b0;
                end
                hold_done = 1'b1;
            end
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(8, 64);
            repeat (stretch) begin
                @(posedge aclk);
                case (mode)
                    0, 1:    m_ready <= 1'b1;
                    2:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [1:0] trap_path [8];
        sagw_in_t   it;
        bit         hold_started;
        bit         pause_done;

        hold_started = 1'b0;
        pause_done   = 1'b0;
        trap_path = '{DIR_COL_INC, DIR_COL_INC, DIR_ROW_INC, DIR_ROW_INC,
                      DIR_COL_DEC, DIR_COL_DEC, DIR_ROW_DEC, DIR_COL_INC};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Origin and far corner, refusals at the low edges, unused op code
        send_fields(OP_READ, DIR_ROW_INC, 4'd0, 4'd0);
        send_fields(OP_READ, DIR_COL_DEC, 4'd15, 4'd15);
        send_fields(OP_MOVE, DIR_ROW_DEC, 4'd15, 4'd0);
        send_fields(OP_MOVE, DIR_COL_DEC, 4'd0, 4'd15);
        send_fields(OP_UNUSED, DIR_COL_DEC, 4'd15, 4'd15);

        // Spiral that boxes the walker in at (1,1), then every direction refused
        foreach (trap_path[i])
            send_fields(OP_MOVE, trap_path[i], 4'd0, 4'd0);
        for (int d = 0; d < 4; d++)
            send_fields(OP_MOVE, 2'(d), 4'd0, 4'd0);
        // move once stuck, read back the trapped cell, then start over
        send_fields(OP_MOVE, DIR_COL_INC, 4'd0, 4'd0);
        send_fields(OP_READ, DIR_ROW_INC, 4'd1, 4'd1);
        send_fields(OP_RESTART, DIR_ROW_INC, 4'd0, 4'd0);
        send_fields(OP_MOVE, DIR_ROW_INC, 4'd0, 4'd0);
        send_fields(OP_READ, DIR_ROW_INC, 4'd1, 4'd0);
        drain();

        // Random walks
        while (walk_items < WALK_ITEMS) begin
            it = next_walk_item();
            send_item(it);
            if (it.op != OP_UNUSED) walk_items++;
            if (!hold_started && walk_items >= HOLD_AT) begin
                // keep offering while the receiver holds off
                hold_started = 1'b1;
                hold_req     = 1'b1;
                while (!hold_done) begin
                    it = next_walk_item();
                    send_item(it);
                    if (it.op != OP_UNUSED) walk_items++;
                end
            end else if (!pause_done && walk_items >= PAUSE_AT) begin
                pause_done = 1'b1;
                drain();
            end else begin
                pace();
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results: %0d moves, %0d refusals, %0d stuck, %0d walks complete",
                 sb.checked, sb.seen[ST_MOVED], sb.seen[ST_REFUSED], sb.seen[ST_STUCK],
                 sb.seen[ST_COMPLETE]);
        $display("Reads %0d, restarts %0d, errors %0d",
                 sb.seen[ST_READ], sb.seen[ST_RESTART], sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/sagw_pkg.sv
design/sagw_ram.sv
design/self_avoiding_grid_walk_core.sv
design/sagw_checker.sv
tb/sv/tb_top.sv
